// ===== rtl/ris_pkg.sv =====
// Package with shared types and constants of the radial isolation sum.
package ris_pkg;

    localparam int unsigned SUM_W = 40;
    localparam int unsigned ISO_W = 24;
    localparam int unsigned PT_W  = 16;
    localparam int unsigned ANG_W = 13;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_CAND = 1'b1;

    localparam logic [2:0] KIND_ELECTRON = 3'd1;
    localparam logic [2:0] KIND_MUON     = 3'd2;
    localparam logic [2:0] KIND_PHOTON   = 3'd3;

    localparam logic REG_PHOTON_MIN  = 1'b0;
    localparam logic REG_NEUTRAL_MIN = 1'b1;

    typedef struct packed {
        logic func;
        logic signed [ANG_W-1:0] eta;
        logic signed [ANG_W-1:0] phi;
        logic [PT_W-1:0] pt;
        logic has_track;
        logic same_track;
        logic [2:0] kind;
        logic last;
    } t_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic sqrt_step;
        logic accum;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_load;
        logic is_last;
    } t_status;

endpackage

// ===== rtl/ris_if.sv =====
// Valid/ready channel interface with a generic payload.
interface ris_if #(
    parameter int unsigned W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/radial_isolation_sum.sv =====
// Top level of the radial isolation sum block.
//
//  channel   direction  payload
//  in_ch     sink       func, eta, phi, pt, has_track, same_track, kind, last
//  out_ch    source     isolation
//  cfg       write      photon_pt_min (0), neutral_pt_min (1)
//
// A candidate goes through capture, 16 square-root steps and accumulate.
// A start item skips the square-root steps. An item marked last adds 40 divider steps and
// a load of the quotient into the output register, where it waits for
// its transfer while the next item is taken. A further result holds the block
// until that register is free. Reset is synchronous, active low, and clears
// muon, sum and threshold registers. The restoring divider produces one quotient bit per cycle.
module radial_isolation_sum #(
    parameter int unsigned ANGLE_FRAC_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ris_if.sink         in_ch,
    ris_if.source       out_ch,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import ris_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_item   item;

    // The input payload is the packed item in field order.
    assign item = t_item'(in_ch.data);

    ris_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .o_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ris_dp #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_dp (
        .i_clk, .i_rst_n,
        .i_item    (item),
        .i_cmd     (cmd),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_status  (status),
        .o_iso     (out_ch.data)
    );
endmodule

// ===== rtl/ris_ctrl.sv =====
// Sequencer of the radial isolation sum: square root, accumulate and divide.
module ris_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  ris_pkg::t_status i_status,
    output ris_pkg::t_cmd   o_cmd
);
    import ris_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQRT = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam int unsigned SQRT_STEPS = 16;
    localparam int unsigned DIV_STEPS  = SUM_W;

    logic [2:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic       r_oval, n_oval;
    logic       accept;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_oval;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_oval  = r_oval && !i_out_ready;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_SQRT;
                    n_cnt   = '0;
                end
            end
            ST_SQRT: begin
                if (i_status.is_load) begin
                    n_state = ST_ACC;
                end else begin
                    o_cmd.sqrt_step = 1'b1;
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == 6'(SQRT_STEPS - 1)) n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.accum = 1'b1;
                if (i_status.is_last) begin
                    o_cmd.div_init = 1'b1;
                    n_state = ST_DIV;
                    n_cnt   = '0;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_STEPS - 1)) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_oval || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_oval  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_oval  <= n_oval;
        end
    end

`ifndef SYNTHESIS
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == 6'(DIV_STEPS - 1)) |=> (r_state == ST_OUT))
        else $error("divider did not finish");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_in_ready)
        else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped");
`endif
endmodule

// ===== rtl/ris_dp.sv =====
// Datapath: distance, selection, weighted sum and restoring divider.
module ris_dp #(
    parameter int unsigned ANGLE_FRAC_BITS = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ris_pkg::t_item   i_item,
    input  ris_pkg::t_cmd    i_cmd,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [15:0]      i_cfg_data,
    output ris_pkg::t_status o_status,
    output logic [ris_pkg::ISO_W-1:0] o_iso
);
    import ris_pkg::*;

    localparam int unsigned ONE_FIX = 1 << ANGLE_FRAC_BITS;
    localparam int unsigned DR_MIN  = (ONE_FIX + 50) / 100;
    localparam int unsigned DR_MAX  = (ONE_FIX * 3) / 10;
    localparam longint unsigned PI_L =
        ((64'd314159265 << ANGLE_FRAC_BITS) + 64'd50000000) / 64'd100000000;
    localparam logic signed [17:0] PI_FIX = 18'(PI_L);
    localparam logic signed [17:0] TWO_PI = 18'(2 * PI_L);
    localparam int PI_I     = int'(PI_L);
    localparam int PHI_SPAN = int'((1 << ANG_W) - 1);
    localparam int WRAPS    = (PHI_SPAN > PI_I) ?
        (PHI_SPAN - PI_I + 2 * PI_I - 1) / (2 * PI_I) : 0;

    t_item r_item;
    logic signed [ANG_W-1:0] r_m_eta, r_m_phi;
    logic [PT_W-1:0] r_m_pt, r_ph_min, r_nt_min;
    logic [SUM_W-1:0] r_sum;
    logic [31:0] r_x, r_r, r_b;
    logic [SUM_W-1:0] r_quo;
    logic [PT_W:0] r_rem;
    logic [ISO_W-1:0] r_iso;

    // The phi difference is folded by whole turns until it lies within one half turn.
    logic signed [15:0] deta;
    logic signed [17:0] dphi;
    logic [31:0] sq_sum;

    always_comb begin
        deta = 16'(r_item.eta) - 16'(r_m_eta);
        dphi = 18'(r_item.phi) - 18'(r_m_phi);
        for (int k = 0; k < WRAPS; k++) begin
            if (dphi > PI_FIX) dphi = dphi - TWO_PI;
            else if (dphi < -PI_FIX) dphi = dphi + TWO_PI;
        end
    end

    logic signed [31:0] eta_sq, phi_sq;
    assign eta_sq = 32'(deta) * 32'(deta);
    assign phi_sq = 32'(dphi) * 32'(dphi);
    assign sq_sum = 32'(eta_sq) + 32'(phi_sq);

    // One digit of the square root per step.
    logic [31:0] rb;
    assign rb = r_r + r_b;

    logic keep;
    logic [31:0] dr;
    logic [PT_W+ANGLE_FRAC_BITS:0] add;
    logic [SUM_W:0] sum_add;
    logic [ANGLE_FRAC_BITS+1:0] wgt;
    assign dr = r_r;
    always_comb begin
        keep = 1'b1;
        if (r_item.has_track && r_item.same_track) keep = 1'b0;
        if (dr < 32'(DR_MIN) || dr > 32'(DR_MAX)) keep = 1'b0;
        if (r_item.has_track) begin
            if (r_item.kind == KIND_ELECTRON || r_item.kind == KIND_MUON) keep = 1'b0;
        end else if (r_item.kind == KIND_PHOTON) begin
            if (r_item.pt <= r_ph_min) keep = 1'b0;
        end else if (r_item.pt <= r_nt_min) begin
            keep = 1'b0;
        end
        wgt = (ANGLE_FRAC_BITS+2)'(ONE_FIX) - (ANGLE_FRAC_BITS+2)'(3 * dr[ANGLE_FRAC_BITS-1:0]);
        add = (PT_W+ANGLE_FRAC_BITS+1)'(r_item.pt) * (PT_W+ANGLE_FRAC_BITS+1)'(wgt);
        sum_add = {1'b0, r_sum} + (SUM_W+1)'(add);
    end

    // Restoring division of the sum by the muon pt, one quotient bit per step.
    logic [PT_W+1:0] trial;
    assign trial = {r_rem, r_quo[SUM_W-1]} - {2'b0, r_m_pt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_eta <= '0; r_m_phi <= '0; r_m_pt <= '0; r_sum <= '0;
            r_ph_min <= '0; r_nt_min <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx == REG_PHOTON_MIN) r_ph_min <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == REG_NEUTRAL_MIN) r_nt_min <= i_cfg_data;
            if (i_cmd.accum) begin
                if (r_item.func == FUNC_LOAD) begin
                    r_m_eta <= r_item.eta; r_m_phi <= r_item.phi;
                    r_m_pt <= r_item.pt; r_sum <= '0;
                end else if (keep) begin
                    r_sum <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_item <= i_item;
        if (i_cmd.capture) begin
            r_r <= '0;
            r_b <= 32'h4000_0000;
            r_x <= '0;
        end else if (i_cmd.sqrt_step) begin
            if (r_b == 32'h4000_0000 && r_r == '0 && r_x == '0) begin
                if (sq_sum >= r_b) begin
                    r_x <= sq_sum - r_b; r_r <= r_b;
                end else begin
                    r_x <= sq_sum;
                end
                r_b <= r_b >> 2;
            end else begin
                if (r_x >= rb) begin
                    r_x <= r_x - rb; r_r <= (r_r >> 1) + r_b;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_b <= r_b >> 2;
            end
        end
        if (i_cmd.div_init) begin
            r_quo <= (r_item.func == FUNC_LOAD) ? '0 : (keep ? (sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0]) : r_sum);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (!trial[PT_W+1]) begin
                r_rem <= trial[PT_W:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[PT_W-1:0], r_quo[SUM_W-1]};
                r_quo <= {r_quo[SUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            r_iso <= (r_m_pt == '0 || r_quo[SUM_W-1:ISO_W] != '0) ? '1 : r_quo[ISO_W-1:0];
        end
    end

    assign o_status.is_load = (r_item.func == FUNC_LOAD);
    assign o_status.is_last = r_item.last;
    assign o_iso = r_iso;
endmodule
